FILE: rtl/tdp_pkg.sv
// Shared types and constants for the trial-division primality tester.
package tdp_pkg;

    // Width of the number field on the input channel.
    localparam int NUMBER_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/tdp_num_if.sv
// Input channel: one number word per handshake.
interface tdp_num_if;
    logic                            valid;
    logic                            ready;
    logic [tdp_pkg::NUMBER_W-1:0]    number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

FILE: rtl/tdp_res_if.sv
// Result channel: one primality flag per handshake.
interface tdp_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

FILE: rtl/tdp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tdp_div #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [NUM_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] quotient,
    output logic [NUM_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(NUM_WIDTH);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [NUM_WIDTH-1:0] q_reg;
    logic [NUM_WIDTH-1:0] q_next;
    logic [NUM_WIDTH-1:0] rem_reg;
    logic [NUM_WIDTH-1:0] rem_next;
    logic [NUM_WIDTH-1:0] dvs_reg;
    logic [NUM_WIDTH-1:0] dvs_next;
    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;
    logic                 ge;
    logic                 last;

    // q_reg shifts dividend bits out at the top and quotient bits in at the bottom
    assign trial = {rem_reg, q_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign last  = (cnt_reg == CNT_W'(NUM_WIDTH - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[NUM_WIDTH-2:0], ge};
            rem_next = ge ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/trial_division_primality_test_top.sv
// Top level of the trial-division primality tester.
//
//   channel    | dir | payload            | handshake
//   number_ch  | in  | number   [31:0]    | valid / ready
//   result_ch  | out | is_prime [0]       | valid / ready
//
// Each candidate divisor passes through the bit-serial divider (load, NUM_WIDTH
// shift steps, bound and remainder check); candidates run from 2 upward until one
// divides N or exceeds the quotient N / candidate, which then marks N as prime.
// One number is in work at a time; the next word is taken while a result waits.
// Reset clears control only; a stalled result holds the finished item back.
module trial_division_primality_test_top #(
    parameter int NUM_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    tdp_num_if.sink   number_ch,
    tdp_res_if.source result_ch
);

    tdp_pkg::state_t      state_reg;
    tdp_pkg::state_t      state_next;
    logic [NUM_WIDTH-1:0] val_reg;
    logic [NUM_WIDTH-1:0] val_next;
    logic [NUM_WIDTH-1:0] cand_reg;
    logic [NUM_WIDTH-1:0] cand_next;
    logic                 fin_reg;
    logic                 fin_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 res_reg;
    logic                 res_next;

    logic [NUM_WIDTH-1:0] in_val;
    logic                 accept;
    logic                 small_num;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_WIDTH-1:0] quo;
    logic [NUM_WIDTH-1:0] rem;
    logic                 past_bound;
    logic                 factor_hit;
    logic                 slot_free;
    logic                 load_out;

    generate
        if (NUM_WIDTH <= tdp_pkg::NUMBER_W)
        begin : g_narrow
            assign in_val = number_ch.number[NUM_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign in_val = {{(NUM_WIDTH - tdp_pkg::NUMBER_W){1'b0}}, number_ch.number};
        end
    endgenerate

    assign accept     = number_ch.valid && number_ch.ready;
    assign small_num  = (in_val < NUM_WIDTH'(2));
    assign past_bound = (cand_reg > quo);
    assign factor_hit = (rem == '0);
    assign slot_free  = !out_valid_reg || result_ch.ready;

    tdp_div #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (val_next),
        .divisor   (cand_next),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdp_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = small_num ? tdp_pkg::ST_FINISH : tdp_pkg::ST_DIV;
            end
            tdp_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = tdp_pkg::ST_CHECK;
            end
            tdp_pkg::ST_CHECK:
            begin
                if (past_bound || factor_hit)
                    state_next = tdp_pkg::ST_FINISH;
                else
                    state_next = tdp_pkg::ST_DIV;
            end
            tdp_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = tdp_pkg::ST_IDLE;
            end
            default:
                state_next = tdp_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        number_ch.ready = 1'b0;
        div_start       = 1'b0;
        load_out        = 1'b0;
        val_next        = val_reg;
        cand_next       = cand_reg;
        fin_next        = fin_reg;
        case (state_reg)
            tdp_pkg::ST_IDLE:
            begin
                number_ch.ready = 1'b1;
                if (accept)
                begin
                    val_next  = in_val;
                    cand_next = NUM_WIDTH'(2);
                    fin_next  = 1'b0;
                    div_start = !small_num;
                end
            end
            tdp_pkg::ST_DIV:
            begin
            end
            tdp_pkg::ST_CHECK:
            begin
                if (past_bound)
                    fin_next = 1'b1;
                else if (factor_hit)
                    fin_next = 1'b0;
                else
                begin
                    cand_next = cand_reg + 1'b1;
                    div_start = 1'b1;
                end
            end
            tdp_pkg::ST_FINISH:
            begin
                load_out = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            res_next       = fin_reg;
        end
        else if (out_valid_reg && result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        cand_reg <= cand_next;
        fin_reg  <= fin_next;
        res_reg  <= res_next;
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.is_prime = res_reg;

endmodule
